@@ hdl/sit_pkg.sv @@
package sit_pkg;

  // Default table depth
  localparam int DEPTH_DEF = 32;

  // Input item modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DUMP   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_INSERTED   = 2'd0;
  localparam logic [1:0] STATUS_FULL       = 2'd1;
  localparam logic [1:0] STATUS_DUMP_ENTRY = 2'd2;
  localparam logic [1:0] STATUS_EMPTY      = 2'd3;

  // One stored record; letter and number together form the sort key
  typedef struct packed {
    logic [7:0]  letter;
    logic [15:0] number;
    logic [9:0]  tag;
  } entry_t;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE
  } cell_op_t;

  // Broadcast control from the sequencer to the row of cells
  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } cell_ctl_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

endpackage

@@ hdl/sorted_insert_table_unit.sv @@
// Sorted record table, highest key (room letter, then room number) first;
// equal keys keep arrival order. The receiver cannot stall: every result shows
// on the result ports for one cycle with strobe high. An insert is taken
// through a row of compare-and-shift cells and gives its result the cycle after
// it is accepted; busy stays low, so inserts may come every cycle. A dump of N
// entries holds busy high while it streams one entry per cycle out of the head
// cell as the row rotates; the start is taken in idle, the first entry is read
// from the head cell in the first dump step and then registered out, and the
// last one shows in the cycle in which busy is low again. After N steps the
// table is back in place. A dump of an empty table or a full insert gives one
// status result the cycle after it is accepted; a clear gives no result.
module sorted_insert_table_unit #(
  parameter int DEPTH = sit_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  room_letter,
  input  logic [15:0] room_number,
  input  logic [9:0]  record_tag,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [7:0]  out_letter,
  output logic [15:0] out_number,
  output logic [9:0]  out_tag,
  output logic        last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  sit_pkg::state_t    state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [IW-1:0]      idx, idx_next;
  sit_pkg::cell_ctl_t ctl;

  logic        strobe_next;
  logic [1:0]  status_next;
  logic [7:0]  letter_next;
  logic [15:0] number_next;
  logic [9:0]  tag_next;
  logic        last_next;
  logic        dump_last;

  sit_pkg::entry_t ents  [DEPTH];
  logic            keeps [DEPTH];

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sit_pkg::entry_t prev_ent, next_ent;
    logic            prev_keep;

    if (i == 0) begin : g_head
      assign prev_ent  = '0;
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_ent  = ents[i-1];
      assign prev_keep = keeps[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign next_ent = '0;
    end else begin : g_mid
      assign next_ent = ents[i+1];
    end

    sit_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .prev_ent  (prev_ent),
      .next_ent  (next_ent),
      .head_ent  (ents[0]),
      .prev_keep (prev_keep),
      .valid     (count > CW'(i)),
      .is_tail   (count == CW'(i + 1)),
      .ent       (ents[i]),
      .keep      (keeps[i])
    );
  end

  assign busy      = (state == sit_pkg::ST_DUMP);
  assign dump_last = ((CW'(idx) + CW'(1)) == count);

  // Sequencer: next state, cell control and result
  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    ctl.op      = sit_pkg::OP_HOLD;
    ctl.ent     = '{letter: room_letter, number: room_number, tag: record_tag};
    strobe_next = 1'b0;
    status_next = sit_pkg::STATUS_INSERTED;
    letter_next = '0;
    number_next = '0;
    tag_next    = '0;
    last_next   = 1'b0;
    unique case (state)
      sit_pkg::ST_IDLE: begin
        if (start) begin
          unique case (mode)
            sit_pkg::MODE_INSERT: begin
              strobe_next = 1'b1;
              last_next   = 1'b1;
              if (count == CW'(DEPTH)) begin
                status_next = sit_pkg::STATUS_FULL;
              end else begin
                ctl.op      = sit_pkg::OP_INSERT;
                count_next  = count + CW'(1);
                status_next = sit_pkg::STATUS_INSERTED;
              end
            end
            sit_pkg::MODE_DUMP: begin
              if (count == '0) begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                status_next = sit_pkg::STATUS_EMPTY;
              end else begin
                state_next = sit_pkg::ST_DUMP;
                idx_next   = '0;
              end
            end
            sit_pkg::MODE_CLEAR: count_next = '0;
            default: ;
          endcase
        end
      end
      sit_pkg::ST_DUMP: begin
        strobe_next = 1'b1;
        status_next = sit_pkg::STATUS_DUMP_ENTRY;
        letter_next = ents[0].letter;
        number_next = ents[0].number;
        tag_next    = ents[0].tag;
        last_next   = dump_last;
        ctl.op      = sit_pkg::OP_ROTATE;
        idx_next    = idx + IW'(1);
        if (dump_last) begin
          state_next = sit_pkg::ST_IDLE;
        end
      end
      default: state_next = sit_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sit_pkg::ST_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  // Result and step registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    status     <= status_next;
    out_letter <= letter_next;
    out_number <= number_next;
    out_tag    <= tag_next;
    last       <= last_next;
  end

`ifndef SYNTH
  // Fill level never passes the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  // Each dump step yields a result transaction next cycle
  a_dump_strobe: assert property (@(posedge clk) disable iff (rst)
    state == sit_pkg::ST_DUMP |=> strobe && status == sit_pkg::STATUS_DUMP_ENTRY)
    else $error("dump step without result");

  // Dump leaves the fill level alone
  a_dump_count: assert property (@(posedge clk) disable iff (rst)
    state == sit_pkg::ST_DUMP |=> count == $past(count))
    else $error("count changed during dump");

  // Final dump entry lands as the unit frees up
  a_dump_end: assert property (@(posedge clk) disable iff (rst)
    strobe && last && status == sit_pkg::STATUS_DUMP_ENTRY |-> !busy)
    else $error("still busy after final dump entry");

  // Accepted insert into a non-full table grows it by one
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode == sit_pkg::MODE_INSERT && count != CW'(DEPTH)
    |=> count == $past(count) + CW'(1))
    else $error("insert did not grow table");
`endif

endmodule

@@ hdl/sit_cell.sv @@
module sit_cell (
  input  logic               clk,
  input  sit_pkg::cell_ctl_t ctl,
  input  sit_pkg::entry_t    prev_ent,
  input  sit_pkg::entry_t    next_ent,
  input  sit_pkg::entry_t    head_ent,
  input  logic               prev_keep,
  input  logic               valid,
  input  logic               is_tail,
  output sit_pkg::entry_t    ent,
  output logic               keep
);

  sit_pkg::entry_t ent_next;

  // Cell keeps its entry on insert when it is valid and holds a key >= the new key
  assign keep = valid && ({ent.letter, ent.number} >= {ctl.ent.letter, ctl.ent.number});

  // Next entry: hold, take new record, shift down from the left, or rotate up
  always_comb begin
    ent_next = ent;
    unique case (ctl.op)
      sit_pkg::OP_HOLD: ent_next = ent;
      sit_pkg::OP_INSERT: begin
        if (keep) begin
          ent_next = ent;
        end else if (prev_keep) begin
          ent_next = ctl.ent;
        end else begin
          ent_next = prev_ent;
        end
      end
      sit_pkg::OP_ROTATE: ent_next = is_tail ? head_ent : next_ent;
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule
